/* src/flow_threshold_mask_painter_unit_macros.svh */
// Assertion macros for the flow threshold mask painter checker.
// Depends on: nothing; the checker supplies clock and reset in its scope.
`ifndef FLOW_THRESHOLD_MASK_PAINTER_UNIT_MACROS_SVH
`define FLOW_THRESHOLD_MASK_PAINTER_UNIT_MACROS_SVH

// Check a property outside reset.
`define FTMP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FTMP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/ftmp_pkg.sv */
// Shared types and constants for the flow threshold mask painter.
// Depends on: nothing.
package ftmp_pkg;

   localparam int COORD_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int MASK_PORT_W = 64;
   localparam int FIFO_DEPTH  = 2;
   localparam int RECIP_SHIFT = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_THRESHOLD_SQ = 2'd2,
      CSR_HALF_WINDOW  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_SKIP,
      CMD_READ,
      CMD_PAINT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               painted;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] base0;
      logic [COORD_W-1:0] q0;
   } cmd_type;

   typedef struct packed {
      logic [8:0]  frame_width;
      logic [8:0]  frame_height;
      logic [31:0] threshold_sq;
      logic [6:0]  half_window;
   } cfg_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SQ_X,
      F_SQ_Y,
      F_TEST,
      F_DIV,
      F_CORR,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_MODIFY,
      B_DONE
   } back_state_type;

endpackage

/* src/flow_threshold_mask_painter_unit.sv */
// Top level of the flow threshold mask painter: configuration registers and wiring.
// Depends on: ftmp_pkg, ftmp_front, ftmp_cmd_fifo, ftmp_back.
// Request queue (req_push / req_full): a flow vector (req_action 0) is tested against
//   threshold_sq and painted as a clipped square of side 2*half_window+1; a read
//   (req_action 1) returns and clears one mask word of req_read_row / req_read_word.
// Response queue (rsp_empty / rsp_pop): one result per item, in order.
// Configuration (csr_we / csr_index / csr_wdata): write only while idle.
// Front end: one item at a time. Back end: one store port, so each mask word touched
//   is read, then written; a painted square touches each word of its span in every
//   row.
// Reset starts a clearing pass over the mask store, MAX_HEIGHT * words per row
//   words (1024 by default); req_full stays high until it ends.
// A waiting result holds in the output register; the command queue and the front
//   end fill behind it, then req_full rises.
module flow_threshold_mask_painter_unit
   import ftmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int WORD_BITS  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_action,
   input  logic [7:0]             req_point_x,
   input  logic [7:0]             req_point_y,
   input  logic signed [15:0]     req_vel_x,
   input  logic signed [15:0]     req_vel_y,
   input  logic [7:0]             req_read_row,
   input  logic [1:0]             req_read_word,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_painted,
   output logic [MASK_PORT_W-1:0] rsp_mask_word
);

   cfg_type cfg_ff, cfg_in;
   cmd_type front_cmd, fifo_cmd;
   logic    front_push, fifo_full, fifo_empty, back_pop, clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[8:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[8:0];
            CSR_THRESHOLD_SQ: cfg_in.threshold_sq = csr_wdata;
            CSR_HALF_WINDOW:  cfg_in.half_window  = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 9'd256;
         cfg_ff.frame_height <= 9'd256;
         cfg_ff.threshold_sq <= '0;
         cfg_ff.half_window  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ftmp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WORD_BITS  (WORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .hold          (clearing),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_read_row  (req_read_row),
      .req_read_word (req_read_word),
      .cmd_data      (front_cmd),
      .cmd_push      (front_push),
      .cmd_full      (fifo_full)
   );

   ftmp_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (fifo_full),
      .pop       (back_pop),
      .pop_data  (fifo_cmd),
      .empty     (fifo_empty)
   );

   ftmp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WORD_BITS  (WORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (fifo_empty),
      .cmd_data      (fifo_cmd),
      .cmd_pop       (back_pop),
      .clearing      (clearing),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_painted   (rsp_painted),
      .rsp_mask_word (rsp_mask_word)
   );

endmodule

/* src/ftmp_front.sv */
// Front end: accepts items, tests flow speed, clips the square, issues commands.
// Depends on: ftmp_pkg.
module ftmp_front
   import ftmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int WORD_BITS  = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               hold,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [7:0]         req_point_x,
   input  logic [7:0]         req_point_y,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic [7:0]         req_read_row,
   input  logic [1:0]         req_read_word,
   output cmd_type            cmd_data,
   output logic               cmd_push,
   input  logic               cmd_full
);

   localparam int WPR     = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int RECIP   = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int DIV_W   = COORD_W + RECIP_W;

   front_state_type    state_ff, state_in;
   logic [7:0]         px_ff, px_in;
   logic [7:0]         py_ff, py_in;
   logic signed [15:0] vx_ff, vx_in;
   logic signed [15:0] vy_ff, vy_in;
   logic [31:0]        sq_x_ff, sq_x_in;
   logic [31:0]        sq_y_ff, sq_y_in;
   logic [COORD_W-1:0] qe_ff, qe_in;
   cmd_type            cmd_ff, cmd_in;

   logic               accept;
   logic signed [15:0] mul_op;
   logic signed [31:0] mul_prod;
   logic [31:0]        sq_sum;
   logic               exceeded;
   logic [8:0]         w_cl, h_cl;
   logic [COORD_W-1:0] r, cx, cy, lo_x, lo_y, hi_x, hi_y, lim_x, lim_y, clip_x1, clip_y1;
   logic               empty_sq;
   logic [DIV_W-1:0]   div_prod;
   logic [COORD_W-1:0] base_est, rem;
   logic               step;
   logic               read_ok;

   // handshake outputs
   always_comb begin
      req_full = (state_ff != F_IDLE) || hold;
      cmd_push = (state_ff == F_PUSH) && !cmd_full;
      cmd_data = cmd_ff;
   end

   assign accept = req_push && !req_full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = req_action ? F_PUSH : F_SQ_X;
            end
         end
         F_SQ_X: state_in = F_SQ_Y;
         F_SQ_Y: state_in = F_TEST;
         F_TEST: state_in = (exceeded && !empty_sq) ? F_DIV : F_PUSH;
         F_DIV:  state_in = F_CORR;
         F_CORR: state_in = F_PUSH;
         F_PUSH: begin
            if (!cmd_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign mul_op   = (state_ff == F_SQ_Y) ? vy_ff : vx_ff;
   assign mul_prod = mul_op * mul_op;

   assign sq_sum   = sq_x_ff + sq_y_ff;
   assign exceeded = sq_sum > cfg.threshold_sq;

   assign w_cl = (32'(cfg.frame_width) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg.frame_width;
   assign h_cl = (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg.frame_height;

   assign r       = COORD_W'(cfg.half_window);
   assign cx      = COORD_W'(px_ff);
   assign cy      = COORD_W'(py_ff);
   assign lo_x    = (cx >= r) ? cx - r : '0;
   assign lo_y    = (cy >= r) ? cy - r : '0;
   assign hi_x    = cx + r;
   assign hi_y    = cy + r;
   assign lim_x   = COORD_W'(w_cl) - COORD_W'(1);
   assign lim_y   = COORD_W'(h_cl) - COORD_W'(1);
   assign clip_x1 = (hi_x > lim_x) ? lim_x : hi_x;
   assign clip_y1 = (hi_y > lim_y) ? lim_y : hi_y;
   assign empty_sq = (w_cl == '0) || (h_cl == '0) || (lo_x > clip_x1) || (lo_y > clip_y1);

   assign div_prod = DIV_W'(cmd_ff.x0) * DIV_W'(RECIP);
   assign base_est = COORD_W'(int'(qe_ff) * WORD_BITS);
   assign rem      = cmd_ff.x0 - base_est;
   assign step     = rem >= COORD_W'(WORD_BITS);

   assign read_ok = (int'(req_read_row) < MAX_HEIGHT) && (int'(req_read_word) < WPR);

   // datapath
   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      vx_in   = vx_ff;
      vy_in   = vy_ff;
      sq_x_in = sq_x_ff;
      sq_y_in = sq_y_ff;
      qe_in   = qe_ff;
      cmd_in  = cmd_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               px_in = req_point_x;
               py_in = req_point_y;
               vx_in = req_vel_x;
               vy_in = req_vel_y;
               cmd_in         = '0;
               cmd_in.kind    = read_ok ? CMD_READ : CMD_SKIP;
               cmd_in.y0      = COORD_W'(req_read_row);
               cmd_in.q0      = COORD_W'(req_read_word);
            end
         end
         F_SQ_X: sq_x_in = unsigned'(mul_prod);
         F_SQ_Y: sq_y_in = unsigned'(mul_prod);
         F_TEST: begin
            cmd_in.painted = exceeded;
            cmd_in.kind    = (exceeded && !empty_sq) ? CMD_PAINT : CMD_SKIP;
            cmd_in.x0      = lo_x;
            cmd_in.x1      = clip_x1;
            cmd_in.y0      = lo_y;
            cmd_in.y1      = clip_y1;
         end
         F_DIV: qe_in = COORD_W'(div_prod >> RECIP_SHIFT);
         F_CORR: begin
            cmd_in.q0    = step ? qe_ff + COORD_W'(1) : qe_ff;
            cmd_in.base0 = step ? base_est + COORD_W'(WORD_BITS) : base_est;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      qe_ff   <= qe_in;
      cmd_ff  <= cmd_in;
   end

endmodule

/* src/ftmp_cmd_fifo.sv */
// Short command queue between the front end and the mask writer.
// Depends on: ftmp_pkg.
module ftmp_cmd_fifo
   import ftmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   cmd_type          entries_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full     = count_ff == (PTR_W + 1)'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop && !empty) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push && !full) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/ftmp_back.sv */
// Back end: mask store, clearing pass, read-modify-write of mask words, result register.
// Depends on: ftmp_pkg.
module ftmp_back
   import ftmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int WORD_BITS  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  cmd_type                cmd_data,
   output logic                   cmd_pop,
   output logic                   clearing,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic                   rsp_painted,
   output logic [MASK_PORT_W-1:0] rsp_mask_word
);

   localparam int WPR    = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH  = MAX_HEIGHT * WPR;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam logic [WORD_BITS-1:0] ONES = '1;

   logic [WORD_BITS-1:0] mask_mem [DEPTH];

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [COORD_W-1:0]     row_ff, row_in;
   logic [COORD_W-1:0]     k_ff, k_in;
   logic [COORD_W-1:0]     base_ff, base_in;
   logic [ADDR_W-1:0]      row_base_ff, row_base_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_painted_ff, rsp_painted_in;
   logic [MASK_PORT_W-1:0] rsp_mask_word_ff, rsp_mask_word_in;

   logic [ADDR_W-1:0]    addr;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [BIT_W-1:0]     lo, hi;
   logic [COORD_W-1:0]   diff;
   logic                 last_word, last_row;
   logic [WORD_BITS-1:0] paint_mask;

   assign addr = row_base_ff + ADDR_W'(k_ff);

   assign lo        = (cmd_ff.x0 > base_ff) ? BIT_W'(cmd_ff.x0 - base_ff) : '0;
   assign diff      = cmd_ff.x1 - base_ff;
   assign last_word = diff <= COORD_W'(WORD_BITS - 1);
   assign last_row  = row_ff == cmd_ff.y1;
   assign hi        = last_word ? BIT_W'(diff) : BIT_W'(WORD_BITS - 1);
   assign paint_mask = (ONES << lo) & (ONES >> (BIT_W'(WORD_BITS - 1) - hi));

   assign rsp_empty     = !rsp_valid_ff;
   assign rsp_painted   = rsp_painted_ff;
   assign rsp_mask_word = rsp_mask_word_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!cmd_empty && !rsp_valid_ff) begin
               state_in = (cmd_data.kind == CMD_SKIP) ? B_DONE : B_READ;
            end
         end
         B_READ: state_in = B_MODIFY;
         B_MODIFY: begin
            if (cmd_ff.kind == CMD_READ || (last_word && last_row)) begin
               state_in = B_DONE;
            end else begin
               state_in = B_READ;
            end
         end
         B_DONE:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop   = (state_ff == B_IDLE) && !cmd_empty && !rsp_valid_ff;
      clearing  = state_ff == B_CLEAR;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr;
      mem_wdata = '0;
      case (state_ff)
         B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         B_READ: mem_re = 1'b1;
         B_MODIFY: begin
            mem_we    = 1'b1;
            mem_wdata = (cmd_ff.kind == CMD_READ) ? '0 : (rd_data_ff | paint_mask);
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cmd_in           = cmd_ff;
      row_in           = row_ff;
      k_in             = k_ff;
      base_in          = base_ff;
      row_base_in      = row_base_ff;
      clr_in           = clr_ff;
      word_in          = word_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_painted_in   = rsp_painted_ff;
      rsp_mask_word_in = rsp_mask_word_ff;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_CLEAR: clr_in = clr_ff + ADDR_W'(1);
         B_IDLE: begin
            if (cmd_pop) begin
               cmd_in      = cmd_data;
               row_in      = cmd_data.y0;
               k_in        = cmd_data.q0;
               base_in     = cmd_data.base0;
               row_base_in = ADDR_W'(int'(cmd_data.y0) * WPR);
               word_in     = '0;
            end
         end
         B_MODIFY: begin
            if (cmd_ff.kind == CMD_READ) begin
               word_in = rd_data_ff;
            end else if (last_word) begin
               row_in      = row_ff + COORD_W'(1);
               row_base_in = row_base_ff + ADDR_W'(WPR);
               k_in        = cmd_ff.q0;
               base_in     = cmd_ff.base0;
            end else begin
               k_in    = k_ff + COORD_W'(1);
               base_in = base_ff + COORD_W'(WORD_BITS);
            end
         end
         B_DONE: begin
            rsp_valid_in     = 1'b1;
            rsp_painted_in   = cmd_ff.painted;
            rsp_mask_word_in = MASK_PORT_W'(word_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff           <= cmd_in;
      row_ff           <= row_in;
      k_ff             <= k_in;
      base_ff          <= base_in;
      row_base_ff      <= row_base_in;
      word_ff          <= word_in;
      rsp_painted_ff   <= rsp_painted_in;
      rsp_mask_word_ff <= rsp_mask_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mask_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mask_mem[addr];
      end
   end

endmodule

/* src/ftmp_checker.sv */
// Port-level checker for the flow threshold mask painter, bound to the top level.
// Depends on: flow_threshold_mask_painter_unit_macros.svh.
`include "flow_threshold_mask_painter_unit_macros.svh"

module ftmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_painted,
   input logic [63:0] rsp_mask_word
);

   `FTMP_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty, "result queue not empty after reset")

   `FTMP_ASSERT_ALWAYS(a_reset_full, reset |=> req_full, "request taken during clearing pass")

   `FTMP_ASSERT(a_one_at_a_time, req_push && !req_full |=> req_full, "front took a second item")

   `FTMP_ASSERT(a_excl, !rsp_empty && rsp_painted |-> rsp_mask_word == '0, "mask on flow")

   `FTMP_ASSERT(a_hold, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_mask_word), "result moved")

endmodule

bind flow_threshold_mask_painter_unit ftmp_checker u_checker (.*);

/* tb/sv/tb_flow_threshold_mask_painter_unit.sv */
`timescale 1ns / 1ps
// Testbench for flow_threshold_mask_painter_unit: queued flow and read-and-clear requests,
// each result checked against an in-bench mask image, across several register settings.
// Depends on: ftmp_pkg, flow_threshold_mask_painter_unit.
module tb_flow_threshold_mask_painter_unit;
   import ftmp_pkg::*;

   localparam int IMG_MAX    = 256;
   localparam int ROW_WORDS  = 4;
   localparam int MASK_DEPTH = IMG_MAX * ROW_WORDS;

   typedef enum logic {
      ACT_FLOW = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   typedef struct {
      action_type         action;
      logic [7:0]         point_x;
      logic [7:0]         point_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic [7:0]         read_row;
      logic [1:0]         read_word;
   } mask_request_type;

   typedef struct {
      logic        painted;
      logic [63:0] mask_word;
   } mask_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic                   req_action = 1'b0;
   logic [7:0]             req_point_x = '0;
   logic [7:0]             req_point_y = '0;
   logic signed [15:0]     req_vel_x = '0;
   logic signed [15:0]     req_vel_y = '0;
   logic [7:0]             req_read_row = '0;
   logic [1:0]             req_read_word = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic                   rsp_painted;
   logic [MASK_PORT_W-1:0] rsp_mask_word;

   logic [63:0] mask_image [MASK_DEPTH];
   logic [8:0]  shadow_width = 9'd256;
   logic [8:0]  shadow_height = 9'd256;
   logic [31:0] shadow_threshold = '0;
   logic [6:0]  shadow_half = '0;

   mask_request_type request_backlog [$];
   mask_result_type  awaited_results [$];
   mask_request_type offered;
   bit               offering = 1'b0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int rsp_holdoff = 0;
   int mismatches = 0;
   int transfers_in = 0;
   int results_seen = 0;
   int squares_painted = 0;
   int words_nonzero = 0;
   int anchor_x = 128;
   int anchor_y = 128;

   flow_threshold_mask_painter_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_read_row  (req_read_row),
      .req_read_word (req_read_word),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_painted   (rsp_painted),
      .rsp_mask_word (rsp_mask_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void paint_square(int cx, int cy);
      int                 w, h, r, x0, x1, y0, y1;
      logic [IMG_MAX-1:0] span;
      w = (int'(shadow_width) > IMG_MAX) ? IMG_MAX : int'(shadow_width);
      h = (int'(shadow_height) > IMG_MAX) ? IMG_MAX : int'(shadow_height);
      r = int'(shadow_half);
      x0 = (cx - r < 0) ? 0 : cx - r;
      y0 = (cy - r < 0) ? 0 : cy - r;
      x1 = (cx + r > w - 1) ? w - 1 : cx + r;
      y1 = (cy + r > h - 1) ? h - 1 : cy + r;
      span = '0;
      for (int x = x0; x <= x1; x++) span[x] = 1'b1;
      for (int y = y0; y <= y1; y++)
         for (int k = 0; k < ROW_WORDS; k++)
            mask_image[y * ROW_WORDS + k] = mask_image[y * ROW_WORDS + k] | span[k * 64 +: 64];
   endfunction

   function automatic mask_result_type predict_result(mask_request_type q);
      mask_result_type res;
      longint          sx, sy, limit;
      int              idx;
      res.painted = 1'b0;
      res.mask_word = '0;
      if (q.action == ACT_FLOW) begin
         sx = longint'(q.vel_x);
         sy = longint'(q.vel_y);
         limit = longint'({32'd0, shadow_threshold});
         if (sx * sx + sy * sy > limit) begin
            res.painted = 1'b1;
            paint_square(int'(q.point_x), int'(q.point_y));
         end
      end else begin
         idx = int'(q.read_row) * ROW_WORDS + int'(q.read_word);
         res.mask_word = mask_image[idx];
         mask_image[idx] = '0;
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t ns: mismatch on %s, got %h, want %h", $time, field, got, want);
   endtask

   // Accept a request transfer and record what it must return.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         awaited_results.insert(awaited_results.size(), predict_result(offered));
         offering = 1'b0;
         transfers_in++;
      end
   end

   always @(posedge clock) begin : watch_rsp
      mask_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", {63'd0, rsp_painted}, '0);
         end else begin
            want = awaited_results.pop_front();
            if (want.painted) squares_painted++;
            if (want.mask_word != '0) words_nonzero++;
            if (rsp_painted !== want.painted)
               report_mismatch("painted", {63'd0, rsp_painted}, {63'd0, want.painted});
            if (rsp_mask_word !== want.mask_word)
               report_mismatch("mask_word", rsp_mask_word, want.mask_word);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!offering) begin
         if (request_backlog.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
            offered = request_backlog.pop_front();
            offering = 1'b1;
            req_push <= 1'b1;
            req_action <= offered.action;
            req_point_x <= offered.point_x;
            req_point_y <= offered.point_y;
            req_vel_x <= offered.vel_x;
            req_vel_y <= offered.vel_y;
            req_read_row <= offered.read_row;
            req_read_word <= offered.read_word;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rsp_holdoff > 0) begin
         rsp_holdoff--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= (int'($urandom_range(99)) >= recv_stall_pct);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  shadow_width = value[8:0];
         CSR_FRAME_HEIGHT: shadow_height = value[8:0];
         CSR_THRESHOLD_SQ: shadow_threshold = value;
         CSR_HALF_WINDOW:  shadow_half = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(int w, int h, logic [31:0] thr, int hw);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_THRESHOLD_SQ, thr);
      write_csr(CSR_HALF_WINDOW, hw);
   endtask

   // Hold until every request is taken and answered, then let the painter finish.
   task automatic settle();
      int tail;
      while (request_backlog.size() != 0 || offering || awaited_results.size() != 0)
         @(negedge clock);
      tail = 8 * (2 * int'(shadow_half) + 1) + 64;
      repeat (tail) @(negedge clock);
   endtask

   function automatic mask_request_type scrambled_request(action_type act);
      mask_request_type q;
      q.action = act;
      q.point_x = 8'($urandom);
      q.point_y = 8'($urandom);
      q.vel_x = 16'($urandom);
      q.vel_y = 16'($urandom);
      q.read_row = 8'($urandom);
      q.read_word = 2'($urandom);
      return q;
   endfunction

   task automatic add_flow(int px, int py, int vx, int vy);
      mask_request_type q;
      q = scrambled_request(ACT_FLOW);
      q.point_x = px[7:0];
      q.point_y = py[7:0];
      q.vel_x = vx[15:0];
      q.vel_y = vy[15:0];
      request_backlog.insert(request_backlog.size(), q);
   endtask

   task automatic add_read(int row, int word);
      mask_request_type q;
      q = scrambled_request(ACT_READ);
      q.read_row = row[7:0];
      q.read_word = word[1:0];
      request_backlog.insert(request_backlog.size(), q);
   endtask

   function automatic int pick_velocity(int speed);
      int pick;
      pick = int'($urandom_range(99));
      if (pick < 65) return int'($urandom_range(2 * speed)) - speed;
      if (pick < 85) return int'($urandom);
      case ($urandom_range(3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic int pick_coord(int centre, int spread);
      int pick;
      pick = int'($urandom_range(99));
      if (pick < 60) return centre + int'($urandom_range(2 * spread)) - spread;
      if (pick < 80) return int'($urandom_range(255));
      case ($urandom_range(3))
         0: return 0;
         1: return 1;
         2: return 254;
         default: return 255;
      endcase
   endfunction

   // Mostly flows and reads clustered near an anchor that moves now and then, so reads see paint.
   task automatic queue_random(int count, int speed);
      int pick, spread, span_w, span_h;
      spread = int'(shadow_half) + 3;
      span_w = (int'(shadow_width) > 252) ? 255 : int'(shadow_width) + 3;
      span_h = (int'(shadow_height) > 252) ? 255 : int'(shadow_height) + 3;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) begin
            anchor_x = int'($urandom_range(span_w));
            anchor_y = int'($urandom_range(span_h));
         end
         pick = int'($urandom_range(99));
         if (pick < 55) begin
            add_flow(pick_coord(anchor_x, spread), pick_coord(anchor_y, spread),
                     pick_velocity(speed), pick_velocity(speed));
         end else if (pick < 90) begin
            add_read(anchor_y + int'($urandom_range(2 * spread)) - spread,
                     (anchor_x + int'($urandom_range(2 * spread)) - spread) >>> 6);
         end else begin
            add_read(int'($urandom_range(255)), int'($urandom_range(3)));
         end
      end
   endtask

   task automatic run_phase(int w, int h, int hw, int speed, int send_idle, int recv_stall,
                            int count);
      configure(w, h, speed * speed / 2, hw);
      send_idle_pct = send_idle;
      recv_stall_pct = recv_stall;
      queue_random(count, speed);
      settle();
   endtask

   initial begin : stimulus
      for (int i = 0; i < MASK_DEPTH; i++) mask_image[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: full image, zero threshold, single pixel
      add_flow(0, 0, 0, 0);
      add_flow(0, 0, 1, 0);
      add_read(0, 0);
      add_read(0, 0);
      add_flow(255, 255, -32768, -32768);
      add_read(255, 3);
      add_flow(64, 128, 32767, 32767);
      add_read(128, 1);
      settle();

      // largest speed equal to the threshold, then below it
      configure(256, 256, 32'h8000_0000, 127);
      add_flow(128, 128, -32768, -32768);
      add_flow(128, 128, -32768, 32767);
      settle();
      write_csr(CSR_THRESHOLD_SQ, 32'hFFFF_FFFF);
      add_flow(3, 3, -32768, -32768);
      settle();

      // equal speed holds back; larger speed paints the widest square, clipped at the corner
      write_csr(CSR_THRESHOLD_SQ, 32'd25);
      add_flow(0, 0, 3, 4);
      add_flow(0, 0, -3, -5);
      add_read(0, 1);
      add_read(127, 0);
      add_read(128, 0);
      settle();

      // zero width and height: flagged but nothing set
      configure(0, 0, 32'd0, 2);
      add_flow(10, 10, 5, 5);
      add_read(10, 0);
      settle();

      // square fully outside the image, then one across a word boundary
      configure(70, 5, 32'd0, 2);
      add_flow(200, 200, 1, 1);
      add_flow(63, 4, -1, 0);
      add_read(4, 0);
      add_read(4, 1);
      add_read(2, 2);
      settle();

      // dimensions above the store clamp to it
      configure(511, 300, 32'd0, 2);
      add_flow(255, 255, 0, -1);
      add_read(254, 3);
      add_read(255, 3);
      settle();

      run_phase(256, 256, 3, 64, 0, 0, 75);
      run_phase(100, 37, 7, 400, 56, 0, 75);
      run_phase(511, 300, 1, 16, 0, 56, 75);
      run_phase(65, 256, 12, 2000, 6, 6, 75);
      run_phase(1, 1, 0, 8, 56, 56, 50);

      // stall the receiver long enough to back the block up, then drain before resuming
      configure(256, 128, 32'd500000, 5);
      send_idle_pct = 0;
      recv_stall_pct = 20;
      queue_random(70, 1000);
      @(posedge clock);
      rsp_holdoff = 400;
      settle();
      queue_random(50, 1000);
      settle();

      // widest squares on a short image, then read back every word of it
      configure(256, 40, 32'd0, 127);
      send_idle_pct = 0;
      recv_stall_pct = 56;
      queue_random(12, 50);
      for (int row = 0; row < 42; row++)
         for (int word = 0; word < ROW_WORDS; word++) add_read(row, word);
      settle();

      repeat (100) @(negedge clock);
      $display("%0d requests taken, %0d results checked: %0d squares painted, %0d nonzero words",
               transfers_in, results_seen, squares_painted, words_nonzero);
      $display("settings spanned widths 0 to 511, thresholds 0 to all ones, half windows 0 to 127");
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
